// ===== sv/hecb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hecb_pkg;

  localparam int unsigned COORD_W = 8;
  localparam int unsigned COUNT_W = 10;
  localparam int unsigned FRAC_W  = 8;
  localparam int unsigned ID_W    = 32;
  localparam int unsigned TOTAL_W = COORD_W + COUNT_W;
  localparam int unsigned MEAN_W  = COORD_W + FRAC_W;
  localparam int unsigned STEP_W  = $clog2(MEAN_W);

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = QPTR_W + 1;

  localparam logic FUNC_HIT   = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  // one closed event, waiting for its means
  typedef struct packed {
    logic [ID_W-1:0]    pcnt;
    logic [ID_W-1:0]    fcnt;
    logic [COUNT_W-1:0] x_hits;
    logic [COUNT_W-1:0] y_hits;
    logic [TOTAL_W-1:0] x_total;
    logic [TOTAL_W-1:0] y_total;
    logic               overflow;
  } event_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

// ===== sv/hecb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hecb_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          func_i,
  input  wire logic [hecb_pkg::ID_W-1:0]     event_pcnt_i,
  input  wire logic [hecb_pkg::ID_W-1:0]     event_fcnt_i,
  input  wire logic [hecb_pkg::COORD_W-1:0]  hit_x_i,
  input  wire logic [hecb_pkg::COORD_W-1:0]  hit_y_i,
  input  wire hecb_pkg::queue_status_t       q_status_i,
  output logic                               push_o,
  output hecb_pkg::event_t                   push_data_o
);

  localparam logic [hecb_pkg::COUNT_W-1:0] CountMax = '1;

  logic                             have_q, have_d;
  logic [hecb_pkg::ID_W-1:0]        pcnt_q, pcnt_d, fcnt_q, fcnt_d;
  logic [hecb_pkg::TOTAL_W-1:0]     xt_q, xt_d, yt_q, yt_d;
  logic [hecb_pkg::COUNT_W-1:0]     xh_q, xh_d, yh_q, yh_d;
  logic                             ovf_q, ovf_d;

  logic accept;
  logic closing;
  logic id_change;
  logic [hecb_pkg::TOTAL_W-1:0] xt_base, yt_base;
  logic [hecb_pkg::COUNT_W-1:0] xh_base, yh_base;
  logic                         ovf_base;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign id_change  = have_q && ((event_pcnt_i != pcnt_q) || (event_fcnt_i != fcnt_q));
  assign closing    = (func_i == hecb_pkg::FUNC_FLUSH) || id_change;

  assign push_o = accept && closing && have_q && (xh_q != '0) && (yh_q != '0);
  assign push_data_o = '{pcnt: pcnt_q, fcnt: fcnt_q, x_hits: xh_q, y_hits: yh_q,
                         x_total: xt_q, y_total: yt_q, overflow: ovf_q};

  always_comb begin
    have_d = have_q;
    pcnt_d = pcnt_q;
    fcnt_d = fcnt_q;
    xt_d   = xt_q;
    yt_d   = yt_q;
    xh_d   = xh_q;
    yh_d   = yh_q;
    ovf_d  = ovf_q;
    // sums restart when the event closes
    xt_base  = id_change ? '0 : xt_q;
    yt_base  = id_change ? '0 : yt_q;
    xh_base  = id_change ? '0 : xh_q;
    yh_base  = id_change ? '0 : yh_q;
    ovf_base = id_change ? 1'b0 : ovf_q;
    if (accept) begin
      if (func_i == hecb_pkg::FUNC_FLUSH) begin
        have_d = 1'b0;
        pcnt_d = '0;
        fcnt_d = '0;
        xt_d   = '0;
        yt_d   = '0;
        xh_d   = '0;
        yh_d   = '0;
        ovf_d  = 1'b0;
      end else begin
        have_d = 1'b1;
        pcnt_d = event_pcnt_i;
        fcnt_d = event_fcnt_i;
        xt_d   = xt_base;
        yt_d   = yt_base;
        xh_d   = xh_base;
        yh_d   = yh_base;
        ovf_d  = ovf_base;
        if (hit_x_i != '0) begin
          if (xh_base == CountMax) begin
            ovf_d = 1'b1;
          end else begin
            xt_d = xt_base + hecb_pkg::TOTAL_W'(hit_x_i);
            xh_d = xh_base + hecb_pkg::COUNT_W'(1);
          end
        end
        if (hit_y_i != '0) begin
          if (yh_base == CountMax) begin
            ovf_d = 1'b1;
          end else begin
            yt_d = yt_base + hecb_pkg::TOTAL_W'(hit_y_i);
            yh_d = yh_base + hecb_pkg::COUNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      pcnt_q <= '0;
      fcnt_q <= '0;
      xt_q   <= '0;
      yt_q   <= '0;
      xh_q   <= '0;
      yh_q   <= '0;
      ovf_q  <= 1'b0;
    end else begin
      have_q <= have_d;
      pcnt_q <= pcnt_d;
      fcnt_q <= fcnt_d;
      xt_q   <= xt_d;
      yt_q   <= yt_d;
      xh_q   <= xh_d;
      yh_q   <= yh_d;
      ovf_q  <= ovf_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/hecb_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hecb_fifo (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    wr_en_i,
  input  wire hecb_pkg::event_t        wr_data_i,
  input  wire logic                    rd_en_i,
  output hecb_pkg::event_t             rd_data_o,
  output hecb_pkg::queue_status_t      status_o
);

  hecb_pkg::event_t mem_q [hecb_pkg::QUEUE_DEPTH];

  logic [hecb_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [hecb_pkg::QCNT_W-1:0] cnt_q, cnt_d;
  logic do_wr, do_rd;

  assign status_o.full  = (cnt_q == hecb_pkg::QCNT_W'(hecb_pkg::QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_wr = wr_en_i && !status_o.full;
  assign do_rd = rd_en_i && !status_o.empty;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_wr ? wr_ptr_q + hecb_pkg::QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + hecb_pkg::QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + hecb_pkg::QCNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - hecb_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/hecb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hecb_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire hecb_pkg::queue_status_t       q_status_i,
  input  wire hecb_pkg::event_t              q_data_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [hecb_pkg::ID_W-1:0]          out_pcnt_o,
  output logic [hecb_pkg::ID_W-1:0]          out_fcnt_o,
  output logic [hecb_pkg::COUNT_W-1:0]       x_count_o,
  output logic [hecb_pkg::COUNT_W-1:0]       y_count_o,
  output logic [hecb_pkg::MEAN_W-1:0]        x_mean_o,
  output logic [hecb_pkg::MEAN_W-1:0]        y_mean_o,
  output logic                               count_overflow_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_OUT  = 3'b100
  } state_e;

  localparam int unsigned RemW = hecb_pkg::COUNT_W;
  localparam int unsigned LowW = hecb_pkg::MEAN_W;

  state_e state_q, state_d;
  logic [hecb_pkg::STEP_W-1:0] step_q, step_d;

  hecb_pkg::event_t ev_q, ev_d;
  logic [RemW-1:0] xrem_q, xrem_d, yrem_q, yrem_d;
  logic [LowW-1:0] xlow_q, xlow_d, ylow_q, ylow_d;
  logic [LowW-1:0] xquo_q, xquo_d, yquo_q, yquo_d;

  logic [RemW:0] xshift, yshift, xdiff, ydiff;
  logic          xge, yge;

  // one restoring-division step per cycle on each axis
  assign xshift = {xrem_q, xlow_q[LowW-1]};
  assign yshift = {yrem_q, ylow_q[LowW-1]};
  assign xdiff  = xshift - {1'b0, ev_q.x_hits};
  assign ydiff  = yshift - {1'b0, ev_q.y_hits};
  assign xge    = xshift >= {1'b0, ev_q.x_hits};
  assign yge    = yshift >= {1'b0, ev_q.y_hits};

  assign pop_o = (state_q == S_IDLE) && !q_status_i.empty;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    ev_d    = ev_q;
    xrem_d  = xrem_q;
    yrem_d  = yrem_q;
    xlow_d  = xlow_q;
    ylow_d  = ylow_q;
    xquo_d  = xquo_q;
    yquo_d  = yquo_q;
    case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          ev_d = q_data_i;
          // the upper part of the scaled total is always below the count
          xrem_d = q_data_i.x_total[hecb_pkg::TOTAL_W-1 -: RemW];
          yrem_d = q_data_i.y_total[hecb_pkg::TOTAL_W-1 -: RemW];
          xlow_d = {q_data_i.x_total[hecb_pkg::COORD_W-1:0], hecb_pkg::FRAC_W'(0)};
          ylow_d = {q_data_i.y_total[hecb_pkg::COORD_W-1:0], hecb_pkg::FRAC_W'(0)};
          step_d  = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        xrem_d = xge ? xdiff[RemW-1:0] : xshift[RemW-1:0];
        yrem_d = yge ? ydiff[RemW-1:0] : yshift[RemW-1:0];
        xlow_d = xlow_q << 1;
        ylow_d = ylow_q << 1;
        xquo_d = {xquo_q[LowW-2:0], xge};
        yquo_d = {yquo_q[LowW-2:0], yge};
        step_d = step_q + hecb_pkg::STEP_W'(1);
        if (step_q == hecb_pkg::STEP_W'(LowW - 1)) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    ev_q   <= ev_d;
    xrem_q <= xrem_d;
    yrem_q <= yrem_d;
    xlow_q <= xlow_d;
    ylow_q <= ylow_d;
    xquo_q <= xquo_d;
    yquo_q <= yquo_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign out_valid_o      = (state_q == S_OUT);
  assign out_pcnt_o       = ev_q.pcnt;
  assign out_fcnt_o       = ev_q.fcnt;
  assign x_count_o        = ev_q.x_hits;
  assign y_count_o        = ev_q.y_hits;
  assign x_mean_o         = xquo_q;
  assign y_mean_o         = yquo_q;
  assign count_overflow_o = ev_q.overflow;

endmodule

`default_nettype wire

// ===== sv/hit_event_centroid_builder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Hit event centroid builder. Hits are taken one per cycle whenever the event
// queue has room; a hit with a new (pcnt, fcnt) id, or a flush transaction,
// closes the open event, and an event with at least one nonzero x and one
// nonzero y is queued (four entries) for its means. The back end works on one
// queued event at a time: it loads the event, then runs bit-serial division
// (x and y in parallel, one quotient bit each cycle), then holds the result
// until taken; it pops the next event only after that. Hit input stalls only
// while the queue is full.
module hit_event_centroid_builder_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          func_i,
  input  wire logic [hecb_pkg::ID_W-1:0]     event_pcnt_i,
  input  wire logic [hecb_pkg::ID_W-1:0]     event_fcnt_i,
  input  wire logic [hecb_pkg::COORD_W-1:0]  hit_x_i,
  input  wire logic [hecb_pkg::COORD_W-1:0]  hit_y_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [hecb_pkg::ID_W-1:0]          out_pcnt_o,
  output logic [hecb_pkg::ID_W-1:0]          out_fcnt_o,
  output logic [hecb_pkg::COUNT_W-1:0]       x_count_o,
  output logic [hecb_pkg::COUNT_W-1:0]       y_count_o,
  output logic [hecb_pkg::MEAN_W-1:0]        x_mean_o,
  output logic [hecb_pkg::MEAN_W-1:0]        y_mean_o,
  output logic                               count_overflow_o
);

  hecb_pkg::queue_status_t q_status;
  hecb_pkg::event_t        push_data;
  hecb_pkg::event_t        pop_data;
  logic                    push;
  logic                    pop;

  hecb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .event_pcnt_i (event_pcnt_i),
    .event_fcnt_i (event_fcnt_i),
    .hit_x_i      (hit_x_i),
    .hit_y_i      (hit_y_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  hecb_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push),
    .wr_data_i (push_data),
    .rd_en_i   (pop),
    .rd_data_o (pop_data),
    .status_o  (q_status)
  );

  hecb_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_status_i       (q_status),
    .q_data_i         (pop_data),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_pcnt_o       (out_pcnt_o),
    .out_fcnt_o       (out_fcnt_o),
    .x_count_o        (x_count_o),
    .y_count_o        (y_count_o),
    .x_mean_o         (x_mean_o),
    .y_mean_o         (y_mean_o),
    .count_overflow_o (count_overflow_o)
  );

endmodule

`default_nettype wire
